FILE: hw/rtl/bmc3_pkg.sv
package bmc3_pkg;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 13;
  localparam int unsigned CFG_WIDTH_BITS  = 12;
  localparam int unsigned CFG_HEIGHT_BITS = 13;

  localparam int unsigned CFG_WIDTH_RESET  = 640;
  localparam int unsigned CFG_HEIGHT_RESET = 480;

  // Smallest frame side the window logic supports.
  localparam int unsigned MIN_DIM = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_e;

  // Where the output pixel sits in the frame.
  typedef enum logic [1:0] {
    CLS_BORDER = 2'd0,  // outermost ring, passes the input bit
    CLS_RING   = 2'd1,  // second ring, always clear
    CLS_INNER  = 2'd2   // full 3x3 erosion of the dilated image
  } cls_e;

  // One line buffer column: the two previous rows of input and of dilated bits.
  typedef struct packed {
    logic x1;  // input, one row up
    logic x2;  // input, two rows up
    logic d1;  // dilated, one row up
    logic d2;  // dilated, two rows up
  } lb_word_t;

endpackage

FILE: hw/rtl/binary_morph_close_3x3_unit.sv
// Per item, one registered line buffer read and one window stage: an accepted input loads
// stage 1, which moves into the result register once that one is empty or being taken.
// Throughput: one item per cycle unless a stalled result holds stage 1; the closed pixel
// trails its input by two rows plus two pixels, and items after a frame, fillers or not,
// drain the last 2*width+2 pixels, one per item.
// Reset (async, active low): counters cleared, size back to 640x480; the line buffer
// holds no reset, and rows not yet written in the current frame never reach a result.
module binary_morph_close_3x3_unit import bmc3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     pixel_in_i,
  input  logic                     filler_i,
  // result items
  output logic                     res_valid_o,
  input  logic                     res_stall_i,
  output logic                     out_valid_o,
  output logic                     closed_pixel_o,
  output logic                     frame_end_o,
  // configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // Column counter and line buffer address.
  localparam int unsigned ColW    = $clog2(MAX_WIDTH);
  // Frame width/height values.
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW      = $clog2(MAX_HEIGHT + 1);
  // Input row runs two rows past the frame while draining.
  localparam int unsigned RowW    = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned OutRowW = $clog2(MAX_HEIGHT);

  localparam int unsigned WReset =
    (CFG_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RESET;
  localparam int unsigned HReset =
    (CFG_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_HEIGHT_RESET;

  typedef struct packed {
    logic            shift;      // item advances the window (pixel or drain step)
    logic            emit;       // item yields a real output pixel
    logic            inner_d;    // dilated pixel lies inside the frame interior
    logic            pix;
    logic            frame_end;
    cls_e            cls;
    logic [ColW-1:0] col;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 register, then the result register.
  // ---------------------------------------------------------------------------
  logic s1_vld_q, res_vld_q;
  logic res_load, s1_adv, accept, cfg_wr, cfg_abort;

  assign res_load   = ~res_vld_q | ~res_stall_i;
  assign s1_adv     = s1_vld_q & res_load;
  assign in_stall_o = s1_vld_q & ~res_load;
  assign accept     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr     = cfg_valid_i & cfg_ready_o;
  // only a decoded register write restarts the frame
  assign cfg_abort  = cfg_wr & (cfg_index_i inside {CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT});

  // ---------------------------------------------------------------------------
  // Frame size, clamped to the supported range when written.
  // ---------------------------------------------------------------------------
  logic [WW-1:0] w_q, w_clamp, w_m1, w_m2;
  logic [HW-1:0] h_q, h_clamp, h_m1, h_m2;
  logic [31:0]   w_cfg, h_cfg;

  always_comb begin
    w_cfg = 32'(cfg_data_i[CFG_WIDTH_BITS-1:0]);
    h_cfg = 32'(cfg_data_i[CFG_HEIGHT_BITS-1:0]);
    if (w_cfg < 32'(MIN_DIM)) begin
      w_clamp = WW'(MIN_DIM);
    end else if (w_cfg > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(w_cfg);
    end
    if (h_cfg < 32'(MIN_DIM)) begin
      h_clamp = HW'(MIN_DIM);
    end else if (h_cfg > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(h_cfg);
    end
  end

  assign w_m1 = w_q - WW'(1);
  assign w_m2 = w_q - WW'(2);
  assign h_m1 = h_q - HW'(1);
  assign h_m2 = h_q - HW'(2);

  // ---------------------------------------------------------------------------
  // Stage 0: position bookkeeping at accept time. Decisions need only the
  // counters and the filler flag, so the counters move with the transaction.
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]    in_row_q, in_row_d;
  logic [OutRowW-1:0] out_row_q, out_row_d;
  logic drain, take_shift, primed, emit, col_wrap, out_col_wrap, last_row, fend;
  cls_e cls;
  s1_t  s1_q, s1_d;

  always_comb begin
    // past the last input row: every item is a drain step
    drain        = in_row_q >= RowW'(h_q);
    take_shift   = ~filler_i | drain;
    // output starts once 2*width+2 pixels are in
    primed       = (in_row_q > RowW'(2)) |
                   ((in_row_q == RowW'(2)) & (in_col_q >= ColW'(2)));
    emit         = take_shift & primed;
    col_wrap     = WW'(in_col_q) == w_m1;
    out_col_wrap = WW'(out_col_q) == w_m1;
    last_row     = HW'(out_row_q) == h_m1;
    fend         = emit & out_col_wrap & last_row;

    if ((out_row_q == '0) || last_row || (out_col_q == '0) || out_col_wrap) begin
      cls = CLS_BORDER;
    end else if ((out_row_q == OutRowW'(1)) || (HW'(out_row_q) == h_m2) ||
                 (out_col_q == ColW'(1)) || (WW'(out_col_q) == w_m2)) begin
      cls = CLS_RING;
    end else begin
      cls = CLS_INNER;
    end

    s1_d.shift     = take_shift;
    s1_d.emit      = emit;
    s1_d.inner_d   = (in_row_q >= RowW'(2)) & (in_col_q >= ColW'(2)) & ~drain;
    s1_d.pix       = pixel_in_i & ~drain;
    s1_d.frame_end = fend;
    s1_d.cls       = cls;
    s1_d.col       = in_col_q;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_abort) begin
      // a width or height write aborts the frame
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (take_shift) begin
        if (col_wrap) begin
          in_col_d = '0;
          in_row_d = in_row_q + RowW'(1);
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
      end
      if (emit) begin
        if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + OutRowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
      if (fend) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WW'(WReset);
      h_q       <= HW'(HReset);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  w_q <= w_clamp;
          CFG_IMAGE_HEIGHT: h_q <= h_clamp;
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      if (~s1_vld_q | res_load) begin
        s1_vld_q <= accept;
      end
      if (res_load) begin
        res_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: one word per column, read at accept, written back when the
  // item leaves stage 1. Consecutive shifting items hit different columns.
  // ---------------------------------------------------------------------------
  lb_word_t lb_mem [MAX_WIDTH];
  lb_word_t rd_q, wr_word;

  always_ff @(posedge clk_i) begin
    if (accept & take_shift) begin
      rd_q <= lb_mem[in_col_q];
    end
    if (s1_adv & s1_q.shift) begin
      lb_mem[s1_q.col] <= wr_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: 3x3 dilation of the newest input window, then 3x3 erosion of the
  // dilated window. The newest dilated bit is the bottom-right tap of the
  // erosion window, so both happen in the same cycle.
  // ---------------------------------------------------------------------------
  // horizontal taps: r = current row, a = one row up, b = two rows up (input);
  // d/e/f the same for dilated bits
  logic xr1_q, xr2_q, xa1_q, xa2_q, xb1_q, xb2_q;
  logic dd1_q, dd2_q, de1_q, de2_q, df1_q, df2_q;
  logic dil, ero, closed;

  always_comb begin
    dil = s1_q.inner_d & (s1_q.pix | xr1_q | xr2_q |
                          rd_q.x1  | xa1_q | xa2_q |
                          rd_q.x2  | xb1_q | xb2_q);
    ero = dil     & dd1_q & dd2_q &
          rd_q.d1 & de1_q & de2_q &
          rd_q.d2 & df1_q & df2_q;
    case (s1_q.cls)
      CLS_BORDER: closed = xb2_q;  // input bit 2 rows + 2 pixels back
      CLS_RING:   closed = 1'b0;
      CLS_INNER:  closed = ero;
      default:    closed = 1'b0;
    endcase
    wr_word.x1 = s1_q.pix;
    wr_word.x2 = rd_q.x1;
    wr_word.d1 = dil;
    wr_word.d2 = rd_q.d1;
  end

  logic out_valid_q, closed_q, frame_end_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv & s1_q.shift) begin
      xr1_q <= s1_q.pix;
      xr2_q <= xr1_q;
      xa1_q <= rd_q.x1;
      xa2_q <= xa1_q;
      xb1_q <= rd_q.x2;
      xb2_q <= xb1_q;
      dd1_q <= dil;
      dd2_q <= dd1_q;
      de1_q <= rd_q.d1;
      de2_q <= de1_q;
      df1_q <= rd_q.d2;
      df2_q <= df1_q;
    end
    if (s1_adv) begin
      out_valid_q <= s1_q.emit;
      closed_q    <= s1_q.emit & closed;
      frame_end_q <= s1_q.frame_end;
    end
  end

  assign res_valid_o    = res_vld_q;
  assign out_valid_o    = out_valid_q;
  assign closed_pixel_o = closed_q;
  assign frame_end_o    = frame_end_q;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import bmc3_pkg::*;

  localparam int unsigned MAX_W      = 2048;
  localparam int unsigned MAX_H      = 4096;
  // Ring of recent pixels, long enough for two rows of the widest frame plus slack.
  localparam int unsigned HIST_LEN   = 2 * MAX_W + 4;
  localparam int unsigned TIMEOUT_NS = 1_200_000;  // run time limit in ns (12 ns clock period)

  // Register indexes the block does not decode; writes to them must not disturb anything.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_UNUSED3 = 2'd3;

  typedef struct packed {
    logic vld;
    logic px;
    logic fend;
  } close_res_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                     clk_i;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     pixel_in_i     = 1'b0;
  logic                     filler_i       = 1'b0;
  logic                     res_stall_i    = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i     = '0;
  logic                     in_stall_o;
  logic                     res_valid_o;
  logic                     out_valid_o;
  logic                     closed_pixel_o;
  logic                     frame_end_o;
  logic                     cfg_ready_o;

  binary_morph_close_3x3_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .filler_i       (filler_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_valid_o    (out_valid_o),
    .closed_pixel_o (closed_pixel_o),
    .frame_end_o    (frame_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Closing predictor: mirrors the block's frame position, pixel history and
  // dilated history. Each accepted input transaction yields exactly one result.
  // ---------------------------------------------------------------------------
  bit          hist_px [HIST_LEN];
  bit          dil_px  [HIST_LEN];
  int unsigned m_col, m_row, m_ocnt;
  int unsigned m_width  = CFG_WIDTH_RESET;
  int unsigned m_height = CFG_HEIGHT_RESET;

  close_res_t  expected_px [$];
  int unsigned err_cnt, items_sent, frames_seen, reg_writes;
  int unsigned burst_left;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
  endfunction

  // 3x3 OR over the pixel history (dilate) or AND over the dilated history (erode).
  function automatic bit win3(bit erode, int unsigned pos, int unsigned w);
    bit          acc;
    bit          v;
    int unsigned base;
    int unsigned idx;
    acc  = erode;
    base = pos - w - 1;
    for (int unsigned dr = 0; dr < 3; dr++) begin
      for (int unsigned dc = 0; dc < 3; dc++) begin
        idx = (base + dr * w + dc) % HIST_LEN;
        v   = erode ? dil_px[idx] : hist_px[idx];
        acc = erode ? (acc & v) : (acc | v);
      end
    end
    return acc;
  endfunction

  function automatic close_res_t predict_close(bit pix, bit fill);
    close_res_t  res;
    int unsigned w, h, total, n, d, q, r, c;
    bit          v;
    w     = clamp_dim(m_width, MAX_W);
    h     = clamp_dim(m_height, MAX_H);
    total = w * h;
    if (m_col >= w || m_row > h || m_ocnt >= total) begin
      m_col  = 0;
      m_row  = 0;
      m_ocnt = 0;
    end
    n = m_row * w + m_col;

    // Take the pixel unless it is a filler or the frame input is already complete.
    if (!fill && m_row < h) begin
      hist_px[n % HIST_LEN] = pix;
      if (n >= w + 1) begin
        d = n - w - 1;
        v = 1'b0;
        if (d / w >= 1 && d / w + 2 <= h && d % w >= 1 && d % w + 2 <= w)
          v = win3(1'b0, d, w);
        dil_px[d % HIST_LEN] = v;
      end
      n++;
      m_col++;
      if (m_col >= w) begin
        m_col = 0;
        m_row++;
      end
    end

    res = '0;
    if (n >= m_ocnt + 2 * w + 3 || m_row >= h) begin
      q = m_ocnt;
      r = q / w;
      c = q % w;
      if (r == 0 || r + 1 == h || c == 0 || c + 1 == w)
        v = hist_px[q % HIST_LEN];      // outer ring passes the input
      else if (r == 1 || r + 2 == h || c == 1 || c + 2 == w)
        v = 1'b0;                       // second ring: dilated border is clear
      else
        v = win3(1'b1, q, w);
      res.vld = 1'b1;
      res.px  = v;
      m_ocnt++;
      if (m_ocnt >= total) begin
        res.fend = 1'b1;
        m_col    = 0;
        m_row    = 0;
        m_ocnt   = 0;
      end
    end
    return res;
  endfunction

  // Any decoded register write restarts the frame.
  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:  m_width  = 32'(data[CFG_WIDTH_BITS-1:0]);
      CFG_IMAGE_HEIGHT: m_height = 32'(data[CFG_HEIGHT_BITS-1:0]);
      default:          return;
    endcase
    m_col  = 0;
    m_row  = 0;
    m_ocnt = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver stall pattern, monitor
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall pattern picks a random mode for a random stretch; includes stall-free stretches.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  res_stall_i <= 1'b0;
      STALL_LIGHT: res_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: res_stall_i <= ($urandom_range(0, 3) != 0);
      default:     res_stall_i <= ~res_stall_i;
    endcase
  end

  task automatic check_field(string name, logic exp, logic act);
    if (act !== exp) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, exp, act);
    end
  endtask

  // Predict on input acceptance first, then compare any result accepted on the same edge.
  always @(posedge clk_i) begin : result_mon
    close_res_t exp_r;
    if (rst_ni) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        expected_px.push_back(predict_close(pixel_in_i, filler_i));
      if (res_valid_o === 1'b1 && res_stall_i === 1'b0) begin
        if (expected_px.size() == 0) begin
          err_cnt++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          exp_r = expected_px.pop_front();
          check_field("out_valid", exp_r.vld, out_valid_o);
          check_field("closed_pixel", exp_r.px, closed_pixel_o);
          check_field("frame_end", exp_r.fend, frame_end_o);
          if (frame_end_o === 1'b1) frames_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction; the sender works in bursts separated by random gaps.
  task automatic send_px(input logic pix, input logic fill);
    int unsigned gap;
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    filler_i   <= fill;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending, let every expected result arrive, then cover the pipeline depth.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Back-to-back writes keep valid high; cfg_done drops it once.
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_reg(idx, data);
    reg_writes++;
  endtask

  task automatic cfg_done();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_DATA_BITS-1:0] wd,
                          input logic [CFG_DATA_BITS-1:0] hd);
    go_idle();
    cfg_write(CFG_IMAGE_WIDTH, wd);
    cfg_write(CFG_IMAGE_HEIGHT, hd);
    cfg_done();
  endtask

  // Frame of w x h pixels set with probability pct%, fillers sprinkled in at fill_pct%.
  // cut != 0 stops after that many pixels (frame is later aborted by a write);
  // otherwise 2*w+2 drain items follow, a mix of fillers and ignored pixels.
  task automatic push_frame(int unsigned w, int unsigned h, int unsigned pct,
                            int unsigned fill_pct, int unsigned cut);
    int unsigned npx;
    npx = (cut != 0) ? cut : w * h;
    for (int unsigned k = 0; k < npx; k++) begin
      if ($urandom_range(0, 99) < fill_pct) send_px(1'($urandom_range(0, 1)), 1'b1);
      send_px($urandom_range(0, 99) < pct, 1'b0);
    end
    if (cut == 0) begin
      for (int unsigned k = 0; k < 2 * w + 2; k++)
        send_px(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size 640x480: a short partial frame, later aborted by a size write.
  task automatic test_reset_size();
    push_frame(640, 480, 50, 5, 40);
    go_idle();
  endtask

  // 3x3 frame: mostly set, mid-frame filler, unused-index writes mid-frame,
  // ignored pixels and fillers during drain, a filler between frames.
  task automatic test_directed();
    set_size(3, 3);
    send_px(1'b1, 1'b0);
    send_px(1'b0, 1'b0);
    send_px(1'b1, 1'b0);
    send_px(1'b1, 1'b1);
    send_px(1'b1, 1'b0);
    go_idle();
    cfg_write(CFG_IDX_UNUSED3, '1);
    cfg_write(CFG_IDX_UNUSED2, '0);
    cfg_done();
    repeat (5) send_px(1'b1, 1'b0);
    repeat (4) send_px(1'b1, 1'b0);
    repeat (4) send_px(1'b0, 1'b1);
    send_px(1'b1, 1'b1);
  endtask

  // Size extremes, including out-of-range values that clamp; the largest sizes
  // run as partial frames that a later write aborts.
  task automatic test_extremes();
    set_size(1, 0);                     // 3 x 3 (both clamp up)
    push_frame(3, 3, 50, 10, 0);
    set_size(7, 1);                     // 7 x 3 (height clamps up)
    push_frame(7, 3, 50, 5, 0);
    set_size(1, 13'h1FFF);              // 3 x 4096 (both clamp), partial frame
    push_frame(3, MAX_H, 50, 2, 60);
    set_size(12'hFFF, CFG_DATA_BITS'(MAX_H));  // 2048 x 4096, partial frame
    push_frame(MAX_W, MAX_H, 50, 0, 40);
    go_idle();
  endtask

  // Small random frames with varied density; some cut short, some unused writes.
  task automatic test_random();
    int unsigned start, w, h, pct, cut;
    logic [CFG_DATA_BITS-1:0] wd;
    bit reconf;
    start  = items_sent;
    reconf = 1'b1;                      // previous test left a frame open
    w      = 3;
    h      = 3;
    while (items_sent - start < 300) begin
      if (reconf || $urandom_range(0, 3) == 0) begin
        w  = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(3, 12);
        h  = ($urandom_range(0, 4) == 0) ? 3 : $urandom_range(3, 10);
        wd = CFG_DATA_BITS'(w);
        wd[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));  // above the width field, dropped
        set_size(wd, CFG_DATA_BITS'(h));
      end else if ($urandom_range(0, 7) == 0) begin
        go_idle();
        cfg_write($urandom_range(0, 1) ? CFG_IDX_UNUSED2 : CFG_IDX_UNUSED3,
                  CFG_DATA_BITS'($urandom()));
        cfg_done();
      end
      pct    = 5 + 22 * $urandom_range(0, 4);
      cut    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : 0;
      reconf = (cut != 0);
      push_frame(w, h, pct, $urandom_range(0, 1) ? 0 : 10, cut);
      if ($urandom_range(0, 3) == 0) send_px(1'($urandom_range(0, 1)), 1'b1);
    end
    go_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_directed();
    test_extremes();
    test_random();

    repeat (10) @(posedge clk_i);
    if (expected_px.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, expected_px.size());
    end

    $display("Covered %0d input transactions, %0d closed frames, %0d register writes",
             items_sent, frames_seen, reg_writes);
    $display("Small full frames with drain, clamped sizes, large partial frames, aborts");
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: run timed out", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
